// ----- rtl/her_pkg.sv -----
// Shared types, constants and helper functions for the hash expert router.
package her_pkg;

  localparam int TOKEN_W     = 64;
  localparam int LAYER_W     = 10;
  localparam int EXPERT_W    = 8;
  localparam int COUNT_W     = 9;
  localparam int PICK_W      = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 9;
  localparam int MAX_EXPERTS = 256;
  localparam int MAX_PICKS   = 8;
  localparam int STRIDE      = 7;
  localparam int TOKEN_MUL   = 5;
  localparam int LAYER_MUL   = 3;
  localparam int DIGIT_W     = 8;
  localparam int SUM_W       = 67;
  localparam int NUM_CELLS   = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int WORD_W      = NUM_CELLS * DIGIT_W;
  localparam int GAP_W       = $clog2(MAX_PICKS);
  localparam int MAX_CYCLE   = MAX_EXPERTS / STRIDE;
  localparam int SMALL_IDX_W = $clog2(STRIDE + 1);

  // Stride modulo each expert count up to the stride itself; entry zero holds the stride.
  localparam logic [STRIDE:0][EXPERT_W-1:0] STRIDE_MOD_SMALL = {
    EXPERT_W'(STRIDE % 7), EXPERT_W'(STRIDE % 6), EXPERT_W'(STRIDE % 5),
    EXPERT_W'(STRIDE % 4), EXPERT_W'(STRIDE % 3), EXPERT_W'(STRIDE % 2),
    EXPERT_W'(STRIDE % 1), EXPERT_W'(STRIDE)};

  localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PICKS        = CFG_IDX_W'(1);

  typedef struct packed {
    logic                valid;
    logic [EXPERT_W-1:0] rem;
    logic [WORD_W-1:0]   word;
  } cell_bus_t;

  // Reports whether the configured pick count cannot be served.
  function automatic logic cfg_bad(input logic [COUNT_W-1:0] e,
                                   input logic [PICK_W-1:0] k);
    logic [COUNT_W-1:0] cyc;
    cyc = e;
    for (int i = 1; i <= MAX_CYCLE; i++) begin
      if (e == COUNT_W'(i * STRIDE)) begin
        cyc = COUNT_W'(i);
      end
    end
    return (e == '0) || (e > COUNT_W'(MAX_EXPERTS)) || (k == '0) ||
           (k > PICK_W'(MAX_PICKS)) || (COUNT_W'(k) > cyc);
  endfunction

  // Returns the stride reduced modulo the expert count.
  function automatic logic [EXPERT_W-1:0] stride_mod(input logic [COUNT_W-1:0] e);
    logic [EXPERT_W-1:0] s;
    s = EXPERT_W'(STRIDE);
    if ((e != '0) && (e <= COUNT_W'(STRIDE))) begin
      s = STRIDE_MOD_SMALL[e[SMALL_IDX_W-1:0]];
    end
    return s;
  endfunction

endpackage

// ----- rtl/her_cell.sv -----
// One reduction cell: folds one digit of the hash word into the running remainder.
module her_cell import her_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] expert_count,
  input  cell_bus_t          bus_in,
  output cell_bus_t          bus_out
);

  logic [EXPERT_W-1:0] rem_next;
  logic [EXPERT_W:0]   trial;

  always_comb begin
    rem_next = bus_in.rem;
    trial    = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      trial = {rem_next, bus_in.word[WORD_W-1-j]};
      if ({1'b0, trial} >= {1'b0, expert_count}) begin
        trial = trial - expert_count;
      end
      rem_next = trial[EXPERT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out.valid <= bus_in.valid;
    end
    bus_out.rem  <= rem_next;
    bus_out.word <= {bus_in.word[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
  end

endmodule

// ----- rtl/her_emitter.sv -----
// Result emitter: walks the stride sequence from the start index, one result per cycle.
module her_emitter import her_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [COUNT_W-1:0]  expert_count,
  input  logic [PICK_W-1:0]   picks_per_token,
  input  logic                bad,
  input  cell_bus_t           bus_in,
  output logic                result_valid,
  output logic [EXPERT_W-1:0] expert_index,
  output logic                is_last,
  output logic                invalid
);

  logic                active;
  logic                bad_q;
  logic [EXPERT_W-1:0] idx;
  logic [PICK_W-1:0]   left;
  logic [EXPERT_W:0]   sum;
  logic [EXPERT_W-1:0] idx_next;
  logic                last_now;

  assign last_now = bad_q || (left == PICK_W'(1));

  always_comb begin
    sum = {1'b0, idx} + {1'b0, stride_mod(expert_count)};
    if (sum >= expert_count) begin
      sum = sum - expert_count;
    end
    idx_next = sum[EXPERT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (bus_in.valid) begin
      active <= 1'b1;
    end else if (active && last_now) begin
      active <= 1'b0;
    end
    if (bus_in.valid) begin
      idx   <= bus_in.rem;
      left  <= picks_per_token;
      bad_q <= bad;
    end else if (active) begin
      idx  <= idx_next;
      left <= left - PICK_W'(1);
    end
  end

  assign result_valid = active;
  assign expert_index = (active && !bad_q) ? idx : '0;
  assign is_last      = active && last_now;
  assign invalid      = active && bad_q;

endmodule

// ----- rtl/hash_expert_router.sv -----
// Top level of the hash expert router: config registers, hash stage, cell chain, emitter.
//
// A request is taken when start is high and busy is low. Its results leave one per cycle,
// each marked by result_valid for exactly one cycle: a register forms 5*token_num +
// 3*layer_index, nine cells reduce that word modulo the expert count eight bits at a time,
// and the emitter then steps through the stride sequence. A request yields picks_per_token
// results, or one invalid result; busy then stays high until the gap counter, loaded from
// picks_per_token, runs down (it stays low for an invalid one), so the emitter's one result
// per cycle sets the rate. The receiver cannot stall the results.
module hash_expert_router import her_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [TOKEN_W-1:0]    token_num,
  input  logic [LAYER_W-1:0]    layer_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic [EXPERT_W-1:0]   expert_index,
  output logic                  is_last,
  output logic                  invalid
);

  logic [COUNT_W-1:0] expert_count;
  logic [PICK_W-1:0]  picks_per_token;
  logic               bad;
  logic               accept;
  logic [GAP_W-1:0]   gap;
  cell_bus_t          head;
  cell_bus_t          chain [NUM_CELLS+1];

  assign cfg_ready = 1'b1;
  assign bad       = cfg_bad(expert_count, picks_per_token);
  assign accept    = start && !busy;
  assign busy      = (gap != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      expert_count    <= COUNT_W'(8);
      picks_per_token <= PICK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPERT_COUNT: expert_count    <= cfg_data[COUNT_W-1:0];
        REG_PICKS:        picks_per_token <= cfg_data[PICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (accept) begin
      gap <= bad ? '0 : GAP_W'(picks_per_token - PICK_W'(1));
    end else if (gap != '0) begin
      gap <= gap - GAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= accept;
    end
    head.rem  <= '0;
    head.word <= WORD_W'(token_num) * WORD_W'(TOKEN_MUL)
               + WORD_W'(layer_index) * WORD_W'(LAYER_MUL);
  end

  assign chain[0] = head;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    her_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .expert_count (expert_count),
      .bus_in       (chain[g]),
      .bus_out      (chain[g+1])
    );
  end

  her_emitter u_emit (
    .clk             (clk),
    .rst             (rst),
    .expert_count    (expert_count),
    .picks_per_token (picks_per_token),
    .bad             (bad),
    .bus_in          (chain[NUM_CELLS]),
    .result_valid    (result_valid),
    .expert_index    (expert_index),
    .is_last         (is_last),
    .invalid         (invalid)
  );

endmodule

// ----- rtl/her_checker.sv -----
// Port-level checker for the hash expert router, bound to the top level.
module her_checker import her_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  result_valid,
  input logic [EXPERT_W-1:0]   expert_index,
  input logic                  is_last,
  input logic                  invalid
);

  // A result that is not the last of its request is always followed by another.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |=> result_valid)
    else $error("result burst ended without a last marker");

  // An invalid result stands alone and carries a zero index.
  a_invalid_alone: assert property (@(posedge clk) disable iff (rst)
    invalid |-> result_valid && is_last && (expert_index == '0))
    else $error("invalid result malformed");

  // Within one request no invalid result follows a valid one.
  a_no_late_invalid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |=> !invalid)
    else $error("invalid result inside a burst");

  // Reset leaves the block idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("block not idle after reset");

endmodule

bind hash_expert_router her_checker u_her_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the hash expert router: directed and random requests.
`timescale 1ns / 1ps

module tb;
  import her_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
  localparam logic [TOKEN_W-1:0]   TOKEN_MAX    = '1;
  localparam logic [LAYER_W-1:0]   LAYER_MAX    = '1;
  localparam int                   SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [EXPERT_W-1:0] expert;
    logic                last;
    logic                bad;
  } pick_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [TOKEN_W-1:0]    token_num;
  logic [LAYER_W-1:0]    layer_index;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  result_valid;
  logic [EXPERT_W-1:0]   expert_index;
  logic                  is_last;
  logic                  invalid;

  logic [COUNT_W-1:0] model_experts;
  logic [PICK_W-1:0]  model_picks;
  pick_t              picks_due[$];
  int                 errors = 0;
  int                 requests_sent = 0;
  int                 picks_checked = 0;
  int                 invalid_seen = 0;
  int                 cfg_writes = 0;
  int                 sender_idle_pct = 0;

  hash_expert_router dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .token_num    (token_num),
    .layer_index  (layer_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .expert_index (expert_index),
    .is_last      (is_last),
    .invalid      (invalid)
  );

  always #6 clk = ~clk;

  function automatic void predict_picks(input logic [TOKEN_W-1:0] tok,
                                        input logic [LAYER_W-1:0] layer);
    longint unsigned e;
    longint unsigned k;
    longint unsigned cycle;
    longint unsigned base;
    bit              bad_cfg;
    pick_t           p;
    e = model_experts;
    k = model_picks;
    bad_cfg = (e == 0 || e > MAX_EXPERTS || k == 0 || k > MAX_PICKS);
    if (!bad_cfg) begin
      cycle = (e % STRIDE == 0) ? e / STRIDE : e;
      bad_cfg = (k > cycle);
    end
    if (bad_cfg) begin
      p.expert = '0;
      p.last = 1'b1;
      p.bad = 1'b1;
      picks_due.push_back(p);
    end else begin
      base = ((tok % e) * TOKEN_MUL + (longint'(layer) % e) * LAYER_MUL) % e;
      for (longint unsigned s = 0; s < k; s++) begin
        p.expert = EXPERT_W'((base + (s % e) * STRIDE) % e);
        p.last = (s + 1 == k);
        p.bad = 1'b0;
        picks_due.push_back(p);
      end
    end
  endfunction

  task automatic send_request(input logic [TOKEN_W-1:0] tok, input logic [LAYER_W-1:0] layer);
    start <= 1'b1;
    token_num <= tok;
    layer_index <= layer;
    do @(posedge clk); while (busy !== 1'b0);
    predict_picks(tok, layer);
    requests_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_EXPERT_COUNT) begin
      model_experts = data[COUNT_W-1:0];
    end else if (idx == REG_PICKS) begin
      model_picks = data[PICK_W-1:0];
    end
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] e_data,
                            input logic [CFG_DATA_W-1:0] k_data);
    drain();
    write_reg(REG_EXPERT_COUNT, e_data);
    write_reg(REG_PICKS, k_data);
  endtask

  task automatic pick_random_config;
    int                    r;
    int                    e;
    int                    cyc;
    int                    kmax;
    logic [CFG_DATA_W-1:0] kd;
    r = $urandom_range(19);
    kd = CFG_DATA_W'($urandom);
    if (r == 0) begin
      e = $urandom_range(MAX_EXPERTS + 1, 511);
    end else if (r == 1) begin
      e = 0;
    end else if (r == 2) begin
      e = $urandom_range(1, MAX_EXPERTS);
    end else begin
      if (r < 8) begin
        e = $urandom_range(1, 16);
      end else if (r < 12) begin
        e = STRIDE * $urandom_range(1, MAX_EXPERTS / STRIDE);
      end else if (r < 17) begin
        e = $urandom_range(1, MAX_EXPERTS);
      end else begin
        e = $urandom_range(MAX_EXPERTS - 1, MAX_EXPERTS);
      end
      cyc = (e % STRIDE == 0) ? e / STRIDE : e;
      kmax = (cyc < MAX_PICKS) ? cyc : MAX_PICKS;
      kd[PICK_W-1:0] = PICK_W'($urandom_range(1, kmax));
    end
    set_config(CFG_DATA_W'(e), kd);
  endtask

  task automatic test_reset_values;
    send_request('0, '0);
    send_request(TOKEN_MAX, LAYER_MAX);
    send_request({$urandom, $urandom}, LAYER_W'($urandom));
    drain();
  endtask

  task automatic test_field_extremes;
    set_config(CFG_DATA_W'(MAX_EXPERTS), CFG_DATA_W'(MAX_PICKS));
    send_request('0, '0);
    send_request(TOKEN_MAX, LAYER_MAX);
    send_request(64'h8000_0000_0000_0001, 10'h200);
    set_config(CFG_DATA_W'(MAX_EXPERTS - 1), CFG_DATA_W'(MAX_PICKS));
    send_request(TOKEN_MAX, LAYER_MAX);
    set_config(CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_request(TOKEN_MAX, LAYER_MAX);
    set_config(CFG_DATA_W'(2), CFG_DATA_W'(2));
    send_request(64'h5555_5555_5555_5555, 10'h2AA);
    drain();
  endtask

  task automatic test_invalid_requests;
    logic [CFG_DATA_W-1:0] e_list[14] = '{0, 511, 257, 8, 8, 8, 7, 7, 14, 14, 3, 49, 56, 256};
    logic [CFG_DATA_W-1:0] k_list[14] = '{1, 1, 8, 0, 9'h1FF, 9, 2, 1, 3, 2, 4, 8, 8, 9'h1F0};
    for (int i = 0; i < 14; i++) begin
      set_config(e_list[i], k_list[i]);
      send_request({$urandom, $urandom}, LAYER_W'($urandom));
    end
    drain();
  endtask

  task automatic test_spare_index;
    set_config(CFG_DATA_W'(5), CFG_DATA_W'(3));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    send_request({$urandom, $urandom}, LAYER_W'($urandom));
    send_request({$urandom, $urandom}, LAYER_W'($urandom));
    drain();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 15 == 0) begin
        pick_random_config();
      end else if ($urandom_range(99) < 4) begin
        drain();
      end
      send_request({$urandom, $urandom}, LAYER_W'($urandom));
    end
    drain();
  endtask

  always @(posedge clk) begin : check_results
    pick_t want;
    if (!rst && result_valid === 1'b1) begin
      if (picks_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expert %0d last %0b invalid %0b",
                 $time, expert_index, is_last, invalid);
      end else begin
        want = picks_due.pop_front();
        picks_checked++;
        if (invalid === 1'b1) invalid_seen++;
        if (expert_index !== want.expert) begin
          errors++;
          $display("%0t: expert_index expected %0d actual %0d", $time, want.expert, expert_index);
        end
        if (is_last !== want.last) begin
          errors++;
          $display("%0t: is_last expected %0b actual %0b", $time, want.last, is_last);
        end
        if (invalid !== want.bad) begin
          errors++;
          $display("%0t: invalid expected %0b actual %0b", $time, want.bad, invalid);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    token_num <= '0;
    layer_index <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    model_experts = COUNT_W'(8);
    model_picks = PICK_W'(1);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 16;
    test_reset_values();
    test_field_extremes();
    test_invalid_requests();
    test_spare_index();
    test_random_traffic(16, 52);
    test_random_traffic(49, 52);
    test_random_traffic(0, 52);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests under %0d register writes; checked %0d results, %0d invalid.",
             requests_sent, cfg_writes, picks_checked, invalid_seen);
    $display("Covered reset values, field extremes, rejected settings and mixed idling.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
